[hw/rtl/chr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// chr_pkg
// Shared types and constants of the consistent hash ring.
// ---------------------------------------------------------------------------
package chr_pkg;

   localparam int VNODES_EACH  = 16;
   localparam int RING_DEPTH   = 1024;
   localparam int NODE_ID_BITS = 16;

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   // decimal digit slots of the node id and vnode index in labels
   localparam int NODE_DIGITS = 5;
   localparam int VN_DIGITS   = 3;

   localparam logic [31:0] HSEED = 32'h5bd1e995;

   typedef enum logic [2:0] {
      FN_KEY    = 3'd0,
      FN_ADD    = 3'd1,
      FN_REMOVE = 3'd2,
      FN_OWN    = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MM_BLOCK  = 2'd0,
      MM_TAIL   = 2'd1,
      MM_FINISH = 2'd2
   } mm_op_type;

   typedef struct packed {
      logic        start;
      mm_op_type   op;
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] len;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] h;
   } mm_rsp_type;

   typedef struct packed {
      logic [15:0] node;
      logic [31:0] hash;
   } entry_type;

endpackage
`default_nettype wire

[hw/rtl/chr_req_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// chr_req_if
// Request channel: operation word with valid/ready.
// ---------------------------------------------------------------------------
interface chr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [15:0] node_id;
   logic [31:0] key_word;
   logic [2:0]  word_bytes;
   logic        last;

   modport source (output valid, func, node_id, key_word, word_bytes, last, input ready);
   modport sink   (input valid, func, node_id, key_word, word_bytes, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/chr_rsp_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// chr_rsp_if
// Response channel: status, owner and span with valid/ready.
// ---------------------------------------------------------------------------
interface chr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] owner_node;
   logic [32:0] owned_span;

   modport source (output valid, status, owner_node, owned_span, input ready);
   modport sink   (input valid, status, owner_node, owned_span, output ready);
endinterface
`default_nettype wire

[hw/rtl/chr_ring_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// chr_ring_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module chr_ring_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/chr_murmur.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// chr_murmur
// MurmurHash3 x86_32 step unit: block mix, tail mix or finalize,
// all on one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
module chr_murmur (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire chr_pkg::mm_req_type mm_req,
   output      chr_pkg::mm_rsp_type mm_rsp
);

   localparam logic [31:0] C1 = 32'hcc9e2d51;
   localparam logic [31:0] C2 = 32'h1b873593;
   localparam logic [31:0] C3 = 32'h85ebca6b;
   localparam logic [31:0] C4 = 32'hc2b2ae35;
   localparam logic [31:0] CA = 32'he6546b64;

   logic                busy_ff;
   logic                done_ff;
   logic [1:0]          step_ff;
   chr_pkg::mm_op_type  op_ff;
   logic [31:0]         h_ff;
   logic [31:0]         k_ff;
   logic [31:0]         len_ff;

   logic [31:0] fin0, fin1, mix, mixr, blk, mul_a, mul_b, prod;

   always_comb begin
      fin0 = h_ff ^ len_ff;
      fin0 = fin0 ^ (fin0 >> 16);
      fin1 = h_ff ^ (h_ff >> 13);
      mix  = h_ff ^ k_ff;
      mixr = {mix[18:0], mix[31:19]};
      blk  = mixr + (mixr << 2) + CA;
      if (step_ff == 2'd0) begin
         mul_a = (op_ff == chr_pkg::MM_FINISH) ? fin0 : k_ff;
         mul_b = (op_ff == chr_pkg::MM_FINISH) ? C3 : C1;
      end else begin
         mul_a = (op_ff == chr_pkg::MM_FINISH) ? fin1 : {k_ff[16:0], k_ff[31:17]};
         mul_b = (op_ff == chr_pkg::MM_FINISH) ? C4 : C2;
      end
      prod = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (mm_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
            op_ff   <= mm_req.op;
            h_ff    <= mm_req.h;
            k_ff    <= mm_req.k;
            len_ff  <= mm_req.len;
         end else if (busy_ff) begin
            if (step_ff != 2'd2) begin
               if (op_ff == chr_pkg::MM_FINISH) h_ff <= prod;
               else k_ff <= prod;
               step_ff <= step_ff + 2'd1;
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               unique case (op_ff)
                  chr_pkg::MM_BLOCK:  h_ff <= blk;
                  chr_pkg::MM_TAIL:   h_ff <= mix;
                  chr_pkg::MM_FINISH: h_ff <= h_ff ^ (h_ff >> 16);
                  default:            h_ff <= h_ff;
               endcase
            end
         end
      end
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.h    = h_ff;

endmodule
`default_nettype wire

[hw/rtl/consistent_hash_ring_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// consistent_hash_ring_top
// Sorted ring of virtual nodes with MurmurHash3 lookup, add, remove,
// ownership and clear.
// ---------------------------------------------------------------------------
// Usage:
//  req_ch carries one word per operation: func, node_id, key_word,
//  word_bytes, last. Key words stream in; a short or last word closes the
//  key and starts the lookup. rsp_ch returns one word per add, remove,
//  ownership, clear and finished key; plain key words and unused codes
//  return nothing.
//  Items are taken one at a time (ready only when the sequencer idles).
//  Work per item is bounded by the hash unit and the one read port of the
//  ring RAM: a key word is one mix; a lookup finalizes the key hash and
//  binary-searches the ring; an add scans the ring for the node, converts
//  the node id to decimal, then hashes each vnode label and shifts larger
//  entries up to insert it; remove and ownership scan the whole ring; clear
//  only resets the count.
//  Reset empties the ring and reseeds the key accumulator; no clearing pass
//  is needed since only entries below the count are read.
//  A result sits in an output register; the next word is accepted while it
//  waits, and the sequencer stalls only when a new result is ready and the
//  receiver still holds off the previous one.
// ---------------------------------------------------------------------------
module consistent_hash_ring_top (
   input  wire logic   clock,
   input  wire logic   reset,
   chr_req_if.sink     req_ch,
   chr_rsp_if.source   rsp_ch
);

   localparam int ADDR_W      = chr_pkg::ADDR_W;
   localparam int CNT_W       = chr_pkg::CNT_W;
   localparam int NB          = chr_pkg::NODE_ID_BITS;
   localparam int ND          = chr_pkg::NODE_DIGITS;
   localparam int VD          = chr_pkg::VN_DIGITS;
   localparam int LBL_BYTES   = 12 + ND + VD;
   localparam int LBL_WORDS   = LBL_BYTES / 4 + 1;
   localparam int LBL_W       = $clog2(LBL_BYTES + 1);
   localparam int WI_W        = $clog2(LBL_WORDS + 2);
   localparam int VC_W        = $clog2(chr_pkg::VNODES_EACH + 1);
   localparam int BIT_W       = $clog2(NB + 1);
   localparam logic [39:0] LBL_HEAD = "node-";
   localparam logic [55:0] LBL_MID  = "-vnode-";

   typedef enum logic [4:0] {
      ST_IDLE, ST_KEY_MIX, ST_KEY_FIN, ST_SRCH_RD, ST_SRCH_CMP, ST_SRCH_NODE,
      ST_ADD_SCAN_RD, ST_ADD_SCAN_CHK, ST_ADD_BCD, ST_ADD_LBL_GO, ST_ADD_LBL_WAIT,
      ST_ADD_LBL_FIN, ST_INS_RD, ST_INS_CMP, ST_RMV_RD, ST_RMV_CHK,
      ST_OWN_LAST_RD, ST_OWN_LAST, ST_OWN_RD, ST_OWN_CHK, ST_DONE
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [31:0]         acc_h_ff;
   logic [31:0]         acc_len_ff;
   logic [31:0]         key_h_ff;
   logic                last_ff;
   logic [15:0]         node_ff;
   logic [CNT_W-1:0]    lo_ff, hi_ff, idx_ff, pos_ff;
   logic [31:0]         prev_ff;
   logic [32:0]         sum_ff;
   logic [NB-1:0]       bin_ff;
   logic [4*ND-1:0]     bcd_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic [VC_W-1:0]     vcnt_ff;
   logic [4*VD-1:0]     vbcd_ff;
   logic [WI_W-1:0]     wi_ff;
   logic [31:0]         lab_h_ff;
   logic [31:0]         new_h_ff;
   logic [1:0]          res_status_ff;
   logic [15:0]         res_owner_ff;
   logic [32:0]         res_span_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [15:0]         rsp_owner_ff;
   logic [32:0]         rsp_span_ff;
   chr_pkg::mm_req_type mm_req_ff;
   chr_pkg::mm_rsp_type mm_rsp;

   chr_pkg::entry_type  rd_ent, wr_ent;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                wr_en;
   logic [CNT_W-1:0]    mid;
   logic                before_hit, ins_done;
   logic [15:0]         node_in;
   logic [31:0]         tail_word;
   logic [LBL_W-1:0]    lab_len;
   logic [8*4*LBL_WORDS-1:0] lbl_vec;
   logic [31:0]         lbl_word;
   logic [32:0]         span;
   logic [4*ND-1:0]     bcd_step;

   chr_murmur u_murmur (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req_ff),
      .mm_rsp (mm_rsp)
   );

   chr_ring_ram #(
      .WIDTH ($bits(chr_pkg::entry_type)),
      .DEPTH (chr_pkg::RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_ent)
   );

   function automatic logic [4*VD-1:0] bcd_inc(input logic [4*VD-1:0] v);
      logic [4*VD-1:0] r;
      logic            c;
      r = v;
      c = 1'b1;
      for (int d = 0; d < VD; d++) begin
         if (c) begin
            if (r[4*d +: 4] == 4'd9) begin
               r[4*d +: 4] = 4'd0;
            end else begin
               r[4*d +: 4] = r[4*d +: 4] + 4'd1;
               c = 1'b0;
            end
         end
      end
      return r;
   endfunction

   assign node_in = 16'(req_ch.node_id[NB-1:0]);
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);

   // short key tail: bytes above word_bytes masked off
   always_comb begin
      unique case (req_ch.word_bytes)
         3'd1:    tail_word = {24'd0, req_ch.key_word[7:0]};
         3'd2:    tail_word = {16'd0, req_ch.key_word[15:0]};
         3'd3:    tail_word = {8'd0, req_ch.key_word[23:0]};
         default: tail_word = req_ch.key_word;
      endcase
   end

   // double-dabble step: add 3 to digits >= 5, then shift in next bit
   always_comb begin
      bcd_step = bcd_ff;
      for (int d = 0; d < ND; d++) begin
         if (bcd_step[4*d +: 4] >= 4'd5) bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
      end
   end

   // label "node-N-vnode-V" as little-endian bytes
   always_comb begin
      int nd;
      int vd;
      nd = 1;
      vd = 1;
      for (int d = 0; d < ND; d++) if (bcd_ff[4*d +: 4] != 4'd0) nd = d + 1;
      for (int d = 0; d < VD; d++) if (vbcd_ff[4*d +: 4] != 4'd0) vd = d + 1;
      lab_len = LBL_W'(12 + nd + vd);
      lbl_vec = '0;
      for (int p = 0; p < 4 * LBL_WORDS; p++) begin
         int r;
         r = p;
         if (r < 5) begin
            lbl_vec[8*p +: 8] = LBL_HEAD[8*(4-r) +: 8];
         end else if (r - 5 < nd) begin
            lbl_vec[8*p +: 8] = 8'h30 + {4'd0, bcd_ff[4*(nd-1-(r-5)) +: 4]};
         end else if (r - 5 - nd < 7) begin
            lbl_vec[8*p +: 8] = LBL_MID[8*(6-(r-5-nd)) +: 8];
         end else if (r - 12 - nd < vd) begin
            lbl_vec[8*p +: 8] = 8'h30 + {4'd0, vbcd_ff[4*(vd-1-(r-12-nd)) +: 4]};
         end
      end
      lbl_word = lbl_vec[32*wi_ff +: 32];
   end

   assign before_hit = (new_h_ff < rd_ent.hash) ||
                       ((new_h_ff == rd_ent.hash) && (node_ff < rd_ent.node));
   assign ins_done   = ((state_ff == ST_INS_RD) && (pos_ff == '0)) ||
                       ((state_ff == ST_INS_CMP) && !before_hit);
   assign span       = (idx_ff == '0) ?
                       (33'h1_0000_0000 + {1'b0, rd_ent.hash} - {1'b0, prev_ff}) :
                       {1'b0, rd_ent.hash - prev_ff};

   // RAM read address per probe state
   always_comb begin
      unique case (state_ff)
         ST_SRCH_RD:     rd_addr = (lo_ff < hi_ff) ? mid[ADDR_W-1:0] :
                                   ((lo_ff >= count_ff) ? '0 : lo_ff[ADDR_W-1:0]);
         ST_ADD_SCAN_RD,
         ST_RMV_RD,
         ST_OWN_RD:      rd_addr = idx_ff[ADDR_W-1:0];
         ST_INS_RD:      rd_addr = ADDR_W'(pos_ff - CNT_W'(1));
         ST_OWN_LAST_RD: rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         default:        rd_addr = '0;
      endcase
   end

   // RAM writes: insertion shift/place, removal compaction
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[ADDR_W-1:0];
      wr_ent  = '{node: node_ff, hash: new_h_ff};
      if (state_ff == ST_INS_RD && pos_ff == '0) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_INS_CMP) begin
         wr_en = 1'b1;
         if (before_hit) wr_ent = rd_ent;
      end else if (state_ff == ST_RMV_CHK && rd_ent.node != node_ff) begin
         wr_en  = 1'b1;
         wr_ent = rd_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         acc_h_ff        <= chr_pkg::HSEED;
         acc_len_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         mm_req_ff.start <= 1'b0;
      end else begin
         mm_req_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  res_status_ff <= chr_pkg::STAT_OK;
                  res_owner_ff  <= '0;
                  res_span_ff   <= '0;
                  node_ff       <= node_in;
                  unique case (req_ch.func)
                     chr_pkg::FN_KEY: begin
                        mm_req_ff.start <= 1'b1;
                        mm_req_ff.h     <= acc_h_ff;
                        if (req_ch.word_bytes >= 3'd4) begin
                           mm_req_ff.op <= chr_pkg::MM_BLOCK;
                           mm_req_ff.k  <= req_ch.key_word;
                           acc_len_ff   <= acc_len_ff + 32'd4;
                           last_ff      <= req_ch.last;
                           state_ff     <= ST_KEY_MIX;
                        end else if (req_ch.word_bytes != 3'd0) begin
                           mm_req_ff.op <= chr_pkg::MM_TAIL;
                           mm_req_ff.k  <= tail_word;
                           acc_len_ff   <= acc_len_ff + {29'd0, req_ch.word_bytes};
                           last_ff      <= 1'b1;
                           state_ff     <= ST_KEY_MIX;
                        end else begin
                           mm_req_ff.op  <= chr_pkg::MM_FINISH;
                           mm_req_ff.len <= acc_len_ff;
                           state_ff      <= ST_KEY_FIN;
                        end
                     end
                     chr_pkg::FN_ADD: begin
                        idx_ff <= '0;
                        if (32'(count_ff) + 32'(chr_pkg::VNODES_EACH) >
                            32'(chr_pkg::RING_DEPTH)) begin
                           res_status_ff <= chr_pkg::STAT_REJECT;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= ST_ADD_SCAN_RD;
                        end
                     end
                     chr_pkg::FN_REMOVE: begin
                        idx_ff   <= '0;
                        pos_ff   <= '0;
                        state_ff <= ST_RMV_RD;
                     end
                     chr_pkg::FN_OWN: begin
                        state_ff <= (count_ff == '0) ? ST_DONE : ST_OWN_LAST_RD;
                     end
                     chr_pkg::FN_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                     default: ;
                  endcase
               end
            end

            // key hashing
            ST_KEY_MIX: begin
               if (mm_rsp.done) begin
                  acc_h_ff <= mm_rsp.h;
                  if (last_ff) begin
                     mm_req_ff.start <= 1'b1;
                     mm_req_ff.op    <= chr_pkg::MM_FINISH;
                     mm_req_ff.h     <= mm_rsp.h;
                     mm_req_ff.len   <= acc_len_ff;
                     state_ff        <= ST_KEY_FIN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_KEY_FIN: begin
               if (mm_rsp.done) begin
                  key_h_ff   <= mm_rsp.h;
                  acc_h_ff   <= chr_pkg::HSEED;
                  acc_len_ff <= '0;
                  lo_ff      <= '0;
                  hi_ff      <= count_ff;
                  if (count_ff == '0) begin
                     res_status_ff <= chr_pkg::STAT_EMPTY;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_SRCH_RD;
                  end
               end
            end

            // lower-bound search, each probe a RAM read then a compare
            ST_SRCH_RD: begin
               idx_ff   <= mid;
               state_ff <= (lo_ff < hi_ff) ? ST_SRCH_CMP : ST_SRCH_NODE;
            end
            ST_SRCH_CMP: begin
               if (rd_ent.hash < key_h_ff) lo_ff <= idx_ff + CNT_W'(1);
               else hi_ff <= idx_ff;
               state_ff <= ST_SRCH_RD;
            end
            ST_SRCH_NODE: begin
               res_owner_ff <= rd_ent.node;
               state_ff     <= ST_DONE;
            end

            // add: duplicate scan, node id to decimal, per-vnode hash + insert
            ST_ADD_SCAN_RD: begin
               if (idx_ff < count_ff) begin
                  state_ff <= ST_ADD_SCAN_CHK;
               end else begin
                  bin_ff   <= node_ff[NB-1:0];
                  bcd_ff   <= '0;
                  bit_ff   <= '0;
                  state_ff <= ST_ADD_BCD;
               end
            end
            ST_ADD_SCAN_CHK: begin
               if (rd_ent.node == node_ff) begin
                  res_status_ff <= chr_pkg::STAT_REJECT;
                  state_ff      <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= ST_ADD_SCAN_RD;
               end
            end
            ST_ADD_BCD: begin
               if (bit_ff == BIT_W'(NB)) begin
                  vcnt_ff  <= '0;
                  vbcd_ff  <= '0;
                  wi_ff    <= '0;
                  lab_h_ff <= chr_pkg::HSEED;
                  state_ff <= ST_ADD_LBL_GO;
               end else begin
                  bcd_ff <= {bcd_step[4*ND-2:0], bin_ff[NB-1]};
                  bin_ff <= bin_ff << 1;
                  bit_ff <= bit_ff + BIT_W'(1);
               end
            end
            ST_ADD_LBL_GO: begin
               mm_req_ff.start <= 1'b1;
               mm_req_ff.h     <= lab_h_ff;
               mm_req_ff.k     <= lbl_word;
               mm_req_ff.len   <= 32'(lab_len);
               if (32'(wi_ff) < 32'(lab_len >> 2)) begin
                  mm_req_ff.op <= chr_pkg::MM_BLOCK;
                  state_ff     <= ST_ADD_LBL_WAIT;
               end else if (32'(wi_ff) == 32'(lab_len >> 2) && lab_len[1:0] != 2'd0) begin
                  mm_req_ff.op <= chr_pkg::MM_TAIL;
                  state_ff     <= ST_ADD_LBL_WAIT;
               end else begin
                  mm_req_ff.op <= chr_pkg::MM_FINISH;
                  state_ff     <= ST_ADD_LBL_FIN;
               end
            end
            ST_ADD_LBL_WAIT: begin
               if (mm_rsp.done) begin
                  lab_h_ff <= mm_rsp.h;
                  wi_ff    <= wi_ff + WI_W'(1);
                  state_ff <= ST_ADD_LBL_GO;
               end
            end
            ST_ADD_LBL_FIN: begin
               if (mm_rsp.done) begin
                  new_h_ff <= mm_rsp.h;
                  pos_ff   <= count_ff;
                  state_ff <= ST_INS_RD;
               end
            end
            ST_INS_RD,
            ST_INS_CMP: begin
               if (ins_done) begin
                  count_ff <= count_ff + CNT_W'(1);
                  vcnt_ff  <= vcnt_ff + VC_W'(1);
                  vbcd_ff  <= bcd_inc(vbcd_ff);
                  lab_h_ff <= chr_pkg::HSEED;
                  wi_ff    <= '0;
                  state_ff <= (vcnt_ff == VC_W'(chr_pkg::VNODES_EACH - 1)) ?
                              ST_DONE : ST_ADD_LBL_GO;
               end else if (state_ff == ST_INS_RD) begin
                  state_ff <= ST_INS_CMP;
               end else begin
                  pos_ff   <= pos_ff - CNT_W'(1);
                  state_ff <= ST_INS_RD;
               end
            end

            // remove: compact survivors down to pos_ff
            ST_RMV_RD: begin
               if (idx_ff < count_ff) begin
                  state_ff <= ST_RMV_CHK;
               end else begin
                  count_ff <= pos_ff;
                  state_ff <= ST_DONE;
               end
            end
            ST_RMV_CHK: begin
               if (rd_ent.node != node_ff) pos_ff <= pos_ff + CNT_W'(1);
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= ST_RMV_RD;
            end

            // ownership: last entry closes the wrap arc of entry 0
            ST_OWN_LAST_RD: state_ff <= ST_OWN_LAST;
            ST_OWN_LAST: begin
               prev_ff  <= rd_ent.hash;
               idx_ff   <= '0;
               sum_ff   <= '0;
               state_ff <= ST_OWN_RD;
            end
            ST_OWN_RD: begin
               if (idx_ff < count_ff) begin
                  state_ff <= ST_OWN_CHK;
               end else begin
                  res_span_ff <= sum_ff;
                  state_ff    <= ST_DONE;
               end
            end
            ST_OWN_CHK: begin
               if (rd_ent.node == node_ff) sum_ff <= sum_ff + span;
               prev_ff  <= rd_ent.hash;
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= ST_OWN_RD;
            end

            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_owner_ff  <= res_owner_ff;
                  rsp_span_ff   <= res_span_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.owner_node = rsp_owner_ff;
   assign rsp_ch.owned_span = rsp_span_ff;

`ifndef ASSERT_OFF
   a_wr_in_ring: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} <= count_ff))
      else $error("ring write beyond entry count");

   a_srch_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_CMP) |-> (lo_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("search probe outside bounds");

   a_key_reseed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KEY_FIN && mm_rsp.done) |=>
         (acc_len_ff == '0) && (acc_h_ff == chr_pkg::HSEED))
      else $error("key accumulator not reseeded after lookup");
`endif

endmodule
`default_nettype wire
